FILE: src/ptm_pkg.sv
// Shared types, codes and default sizes for the profile table merge block.
package ptm_pkg;

  localparam int FUNC_SLOTS_DEF = 64;
  localparam int CALL_SLOTS_DEF = 16;
  localparam int ADDR_BITS_DEF  = 64;

  localparam logic [6:0] FUNC_LIMIT_RST = 7'd64;
  localparam logic [4:0] CALL_LIMIT_RST = 5'd16;

  localparam logic CFG_FUNC_LIMIT = 1'b0;
  localparam logic CFG_CALL_LIMIT = 1'b1;

  typedef enum logic [1:0] {
    KIND_FUNC  = 2'd0,
    KIND_CALL  = 2'd1,
    KIND_READ  = 2'd2,
    KIND_CLEAR = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    STAT_MERGED   = 3'd0,
    STAT_INSERTED = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_IGNORED  = 3'd3,
    STAT_READ     = 3'd4,
    STAT_CLEARED  = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FSCAN,
    ST_CROW,
    ST_CSCAN,
    ST_READ,
    ST_DONE
  } state_t;

  typedef struct packed {
    kind_t        kind;
    logic [63:0]  address;
    logic [63:0]  hits;
    logic [31:0]  site_tag;
    logic [5:0]   func_index;
    logic [3:0]   call_index;
  } item_t;

  typedef struct packed {
    status_t      status;
    logic [5:0]   func_slot;
    logic [3:0]   call_slot;
    logic [63:0]  rd_func_addr;
    logic [63:0]  func_hits;
    logic [4:0]   call_count;
    logic [63:0]  site_address;
    logic [63:0]  site_hits;
    logic [31:0]  site_tag;
  } result_t;

endpackage

FILE: src/ptm_ram.sv
// Single write port, single registered read port memory.
module ptm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

FILE: src/ptm_seq.sv
// Sequencer, shared compare/add unit and table memories.
module ptm_seq #(
  parameter int FUNC_SLOTS = ptm_pkg::FUNC_SLOTS_DEF,
  parameter int CALL_SLOTS = ptm_pkg::CALL_SLOTS_DEF,
  parameter int ADDR_BITS  = ptm_pkg::ADDR_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  ptm_pkg::item_t   item,
  input  logic [6:0]       func_limit,
  input  logic [4:0]       call_limit,
  input  logic             res_ready,
  output logic             idle,
  output logic             done,
  output ptm_pkg::result_t res
);

  localparam int FW    = $clog2(FUNC_SLOTS);
  localparam int FLW   = $clog2(FUNC_SLOTS + 1);
  localparam int CLW   = $clog2(CALL_SLOTS + 1);
  localparam int SDEP  = FUNC_SLOTS * CALL_SLOTS;
  localparam int SAW   = $clog2(SDEP);
  localparam int FWID  = CLW + 64 + ADDR_BITS;
  localparam int SWID  = 32 + 64 + ADDR_BITS;

  ptm_pkg::state_t state, state_next;

  ptm_pkg::item_t it;
  ptm_pkg::result_t res_next;
  logic [FLW-1:0] idx;
  logic [FW-1:0]  prev;
  logic [CLW-1:0] t;
  logic [CLW-1:0] prevt;
  logic           pend;
  logic [FW-1:0]  clr_idx;
  logic           clr_item;
  logic [FW-1:0]  cur_slot;
  logic           cur_valid;
  logic [SAW-1:0] base;
  logic [CLW-1:0] n;
  logic [ADDR_BITS-1:0] row_addr;
  logic [63:0]    row_hits;

  logic [FLW-1:0] flim;
  logic [CLW-1:0] clim;

  // memory ports
  logic            f_we;
  logic [FW-1:0]   f_waddr;
  logic [FWID-1:0] f_wdata;
  logic [FW-1:0]   f_raddr;
  logic [FWID-1:0] f_rdata;
  logic            s_we;
  logic [SAW-1:0]  s_waddr;
  logic [SWID-1:0] s_wdata;
  logic [SAW-1:0]  s_raddr;
  logic [SWID-1:0] s_rdata;

  logic [ADDR_BITS-1:0] f_rd_addr, s_rd_addr, it_addr, in_addr;
  logic [63:0]    f_rd_hits, s_rd_hits, add_a, sum;
  logic [CLW-1:0] f_rd_cnt;
  logic [31:0]    s_rd_tag;
  logic           f_hit, f_empty, f_more, s_hit, s_more, s_room;
  logic           fval, cval, sval;

  ptm_ram #(.WIDTH(FWID), .DEPTH(FUNC_SLOTS)) u_func_ram (
    .clk(clk), .we(f_we), .waddr(f_waddr), .wdata(f_wdata),
    .raddr(f_raddr), .rdata(f_rdata)
  );

  ptm_ram #(.WIDTH(SWID), .DEPTH(SDEP)) u_site_ram (
    .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
    .raddr(s_raddr), .rdata(s_rdata)
  );

  // saturate limits to the table size
  always_comb begin
    if (32'(func_limit) > FUNC_SLOTS) begin
      flim = FLW'(FUNC_SLOTS);
    end else begin
      flim = FLW'(func_limit);
    end
    if (32'(call_limit) > CALL_SLOTS) begin
      clim = CLW'(CALL_SLOTS);
    end else begin
      clim = CLW'(call_limit);
    end
  end

  assign f_rd_addr = f_rdata[ADDR_BITS-1:0];
  assign f_rd_hits = f_rdata[ADDR_BITS +: 64];
  assign f_rd_cnt  = f_rdata[FWID-1 -: CLW];
  assign s_rd_addr = s_rdata[ADDR_BITS-1:0];
  assign s_rd_hits = s_rdata[ADDR_BITS +: 64];
  assign s_rd_tag  = s_rdata[SWID-1 -: 32];
  assign it_addr   = it.address[ADDR_BITS-1:0];
  assign in_addr   = item.address[ADDR_BITS-1:0];

  // shared compare and add unit
  assign add_a   = (state == ptm_pkg::ST_CSCAN) ? s_rd_hits : f_rd_hits;
  assign sum     = add_a + it.hits;
  assign f_hit   = pend && (f_rd_addr == it_addr);
  assign f_empty = pend && (f_rd_addr == '0);
  assign f_more  = idx < flim;
  assign s_hit   = pend && (s_rd_addr == it_addr);
  assign s_more  = t < n;
  assign s_room  = n < clim;

  assign fval = 32'(it.func_index) < FUNC_SLOTS;
  assign cval = 32'(it.call_index) < CALL_SLOTS;
  assign sval = fval && cval && (32'(it.call_index) < 32'(f_rd_cnt));

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ptm_pkg::ST_CLEAR: begin
        if (clr_idx == FW'(FUNC_SLOTS - 1)) begin
          state_next = clr_item ? ptm_pkg::ST_DONE : ptm_pkg::ST_IDLE;
        end
      end
      ptm_pkg::ST_IDLE: begin
        if (start) begin
          case (item.kind)
            ptm_pkg::KIND_FUNC: begin
              state_next = (in_addr == '0 || flim == '0) ? ptm_pkg::ST_DONE
                                                         : ptm_pkg::ST_FSCAN;
            end
            ptm_pkg::KIND_CALL: begin
              state_next = cur_valid ? ptm_pkg::ST_CROW : ptm_pkg::ST_DONE;
            end
            ptm_pkg::KIND_READ:  state_next = ptm_pkg::ST_READ;
            default:             state_next = ptm_pkg::ST_CLEAR;
          endcase
        end
      end
      ptm_pkg::ST_FSCAN: begin
        if (f_hit || f_empty || !f_more) begin
          state_next = ptm_pkg::ST_DONE;
        end
      end
      ptm_pkg::ST_CROW:  state_next = ptm_pkg::ST_CSCAN;
      ptm_pkg::ST_CSCAN: begin
        if (s_hit || !s_more) begin
          state_next = ptm_pkg::ST_DONE;
        end
      end
      ptm_pkg::ST_READ:  state_next = ptm_pkg::ST_DONE;
      ptm_pkg::ST_DONE: begin
        if (res_ready) begin
          state_next = ptm_pkg::ST_IDLE;
        end
      end
      default: state_next = ptm_pkg::ST_IDLE;
    endcase
  end

  // memory controls
  always_comb begin
    f_we    = 1'b0;
    f_waddr = prev;
    f_wdata = '0;
    f_raddr = idx[FW-1:0];
    s_we    = 1'b0;
    s_waddr = base + SAW'(prevt);
    s_wdata = '0;
    s_raddr = base + SAW'(t);
    case (state)
      ptm_pkg::ST_CLEAR: begin
        f_we    = 1'b1;
        f_waddr = clr_idx;
      end
      ptm_pkg::ST_IDLE: begin
        f_raddr = (item.kind == ptm_pkg::KIND_READ) ? FW'(item.func_index) : cur_slot;
        s_raddr = SAW'(FW'(item.func_index)) * SAW'(CALL_SLOTS) + SAW'(item.call_index);
      end
      ptm_pkg::ST_FSCAN: begin
        if (f_hit) begin
          f_we    = 1'b1;
          f_wdata = {f_rd_cnt, sum, f_rd_addr};
        end else if (f_empty) begin
          f_we    = 1'b1;
          f_wdata = {CLW'(0), it.hits, it_addr};
        end
      end
      ptm_pkg::ST_CSCAN: begin
        if (s_hit) begin
          s_we    = 1'b1;
          s_wdata = {s_rd_tag, sum, s_rd_addr};
        end else if (!s_more && s_room) begin
          s_we    = 1'b1;
          s_waddr = base + SAW'(n);
          s_wdata = {it.site_tag, it.hits, it_addr};
          f_we    = 1'b1;
          f_waddr = cur_slot;
          f_wdata = {CLW'(n + 1'b1), row_hits, row_addr};
        end
      end
      default: ;
    endcase
  end

  // result fields, built up over the item
  always_comb begin
    res_next = res;
    case (state)
      ptm_pkg::ST_IDLE: begin
        if (start) begin
          res_next        = '0;
          res_next.status = ptm_pkg::STAT_FULL;
          case (item.kind)
            ptm_pkg::KIND_FUNC: begin
              if (in_addr == '0) begin
                res_next.status = ptm_pkg::STAT_IGNORED;
              end
            end
            ptm_pkg::KIND_CALL: begin
              if (cur_valid) begin
                res_next.func_slot = 6'(cur_slot);
              end else begin
                res_next.status = ptm_pkg::STAT_IGNORED;
              end
            end
            ptm_pkg::KIND_READ: begin
              res_next.status    = ptm_pkg::STAT_READ;
              res_next.func_slot = item.func_index;
              res_next.call_slot = item.call_index;
            end
            default: res_next.status = ptm_pkg::STAT_CLEARED;
          endcase
        end
      end
      ptm_pkg::ST_FSCAN: begin
        if (f_hit || f_empty) begin
          res_next.status    = f_hit ? ptm_pkg::STAT_MERGED : ptm_pkg::STAT_INSERTED;
          res_next.func_slot = 6'(prev);
        end
      end
      ptm_pkg::ST_CSCAN: begin
        if (s_hit) begin
          res_next.status    = ptm_pkg::STAT_MERGED;
          res_next.call_slot = 4'(prevt);
        end else if (!s_more && s_room) begin
          res_next.status    = ptm_pkg::STAT_INSERTED;
          res_next.call_slot = 4'(n);
        end
      end
      ptm_pkg::ST_READ: begin
        res_next.rd_func_addr = fval ? 64'(f_rd_addr) : 64'd0;
        res_next.func_hits    = fval ? f_rd_hits : 64'd0;
        res_next.call_count   = fval ? 5'(f_rd_cnt) : 5'd0;
        res_next.site_address = sval ? 64'(s_rd_addr) : 64'd0;
        res_next.site_hits    = sval ? s_rd_hits : 64'd0;
        res_next.site_tag     = sval ? s_rd_tag : 32'd0;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res <= res_next;
  end

  assign idle = (state == ptm_pkg::ST_IDLE);
  assign done = (state == ptm_pkg::ST_DONE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ptm_pkg::ST_CLEAR;
      clr_idx   <= '0;
      clr_item  <= 1'b0;
      cur_valid <= 1'b0;
      pend      <= 1'b0;
    end else begin
      state <= state_next;
      case (state)
        ptm_pkg::ST_CLEAR: clr_idx <= clr_idx + 1'b1;
        ptm_pkg::ST_IDLE: begin
          if (start) begin
            it         <= item;
            pend       <= 1'b0;
            idx        <= '0;
            t          <= '0;
            case (item.kind)
              ptm_pkg::KIND_FUNC: begin
                cur_valid <= 1'b0;
              end
              ptm_pkg::KIND_CALL: begin
                base <= SAW'(cur_slot) * SAW'(CALL_SLOTS);
              end
              ptm_pkg::KIND_READ: ;
              default: begin
                clr_idx    <= '0;
                clr_item   <= 1'b1;
                cur_valid  <= 1'b0;
              end
            endcase
          end
        end
        ptm_pkg::ST_FSCAN: begin
          pend <= f_more;
          prev <= idx[FW-1:0];
          if (f_more) begin
            idx <= idx + 1'b1;
          end
          if (f_hit || f_empty) begin
            cur_slot      <= prev;
            cur_valid     <= 1'b1;
          end
        end
        ptm_pkg::ST_CROW: begin
          row_addr <= f_rd_addr;
          row_hits <= f_rd_hits;
          n        <= f_rd_cnt;
          pend     <= 1'b0;
          t        <= '0;
        end
        ptm_pkg::ST_CSCAN: begin
          pend  <= s_more;
          prevt <= t;
          if (s_more) begin
            t <= t + 1'b1;
          end
        end
        ptm_pkg::ST_DONE: clr_item <= 1'b0;
        default: ;
      endcase
    end
  end

endmodule

FILE: src/profile_table_merge_core.sv
// Top level: ports, configuration registers, result register, checks.
// Function records scan the function slots, call-site records scan the call sites
// held by the current function; a read looks up one entry, a clear walks every slot.
// The sequencer is idle again in the cycle out_valid rises.
// One item at a time; scans over the table memories set the rate. Reset runs a
// clearing pass over every function slot with in_stall high; limits reset to 64 and 16.
module profile_table_merge_core #(
  parameter int FUNC_SLOTS = ptm_pkg::FUNC_SLOTS_DEF,
  parameter int CALL_SLOTS = ptm_pkg::CALL_SLOTS_DEF,
  parameter int ADDR_BITS  = ptm_pkg::ADDR_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  kind,
  input  logic [63:0] address,
  input  logic [63:0] hits,
  input  logic [31:0] site_tag,
  input  logic [5:0]  func_index,
  input  logic [3:0]  call_index,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status,
  output logic [5:0]  func_slot,
  output logic [3:0]  call_slot,
  output logic [63:0] func_address_out,
  output logic [63:0] func_hits_out,
  output logic [4:0]  call_count_out,
  output logic [63:0] site_address_out,
  output logic [63:0] site_hits_out,
  output logic [31:0] site_tag_out,
  // configuration write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);

  logic [6:0]       func_limit;
  logic [4:0]       call_limit;
  ptm_pkg::item_t   item;
  ptm_pkg::result_t res, out_res;
  logic             idle, done, start, res_ready;

  // Config writes land at once; the user must issue them only while idle, the block does not enforce it.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      func_limit <= ptm_pkg::FUNC_LIMIT_RST;
      call_limit <= ptm_pkg::CALL_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        ptm_pkg::CFG_FUNC_LIMIT: func_limit <= cfg_data;
        ptm_pkg::CFG_CALL_LIMIT: call_limit <= cfg_data[4:0];
        default: ;
      endcase
    end
  end

  // Sequencer takes an item only from its idle state.
  assign in_stall = !idle;
  assign start    = in_valid && idle;

  always_comb begin
    item.kind       = ptm_pkg::kind_t'(kind);
    item.address    = address;
    item.hits       = hits;
    item.site_tag   = site_tag;
    item.func_index = func_index;
    item.call_index = call_index;
  end

  ptm_seq #(
    .FUNC_SLOTS(FUNC_SLOTS),
    .CALL_SLOTS(CALL_SLOTS),
    .ADDR_BITS (ADDR_BITS)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .item      (item),
    .func_limit(func_limit),
    .call_limit(call_limit),
    .res_ready (res_ready),
    .idle      (idle),
    .done      (done),
    .res       (res)
  );

  // Result register: parts the sequencer from a stalled consumer, so the
  // next item can be taken while a finished result waits for its transfer.
  assign res_ready = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= done;
    end
  end

  always_ff @(posedge clk) begin
    if (done && res_ready) begin
      out_res <= res;
    end
  end

  assign status           = 3'(out_res.status);
  assign func_slot        = out_res.func_slot;
  assign call_slot        = out_res.call_slot;
  assign func_address_out = out_res.rd_func_addr;
  assign func_hits_out    = out_res.func_hits;
  assign call_count_out   = out_res.call_count;
  assign site_address_out = out_res.site_address;
  assign site_hits_out    = out_res.site_hits;
  assign site_tag_out     = out_res.site_tag;

  // An accepted item keeps the block busy in the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input accepted twice in a row");

  // A finished result handed over must show up at the output.
  a_result_lands: assert property (@(posedge clk) disable iff (rst)
    (done && res_ready) |=> out_valid)
    else $error("finished result lost");

  // The clearing pass holds off input right after reset.
  a_clear_after_reset: assert property (@(posedge clk)
    $fell(rst) |-> in_stall)
    else $error("input open during clearing pass");

endmodule
